@@ sv/rwcw_pkg.sv @@
// Shared types, phase codes and event codes for the RIFF/WebP chunk walker.
`timescale 1ns / 1ps
`default_nettype none
package rwcw_pkg;

  localparam logic [31:0] TAG_RIFF    = 32'h4646_4952;
  localparam logic [31:0] TAG_WEBP    = 32'h5042_4557;
  localparam logic [31:0] TAG_VP8SP   = 32'h2038_5056;
  localparam logic [32:0] HEADER_BIAS = 33'd8;

  localparam logic [3:0] PH_RIFF    = 4'd0;
  localparam logic [3:0] PH_RSIZE   = 4'd1;
  localparam logic [3:0] PH_WEBP    = 4'd2;
  localparam logic [3:0] PH_CTAG    = 4'd3;
  localparam logic [3:0] PH_OSIZE   = 4'd4;
  localparam logic [3:0] PH_TSIZE   = 4'd5;
  localparam logic [3:0] PH_SKIP    = 4'd6;
  localparam logic [3:0] PH_PAYLOAD = 4'd7;
  localparam logic [3:0] PH_DONE    = 4'd8;

  localparam logic [2:0] EV_CONSUMED = 3'd0;
  localparam logic [2:0] EV_FOUND    = 3'd1;
  localparam logic [2:0] EV_PAYLOAD  = 3'd2;
  localparam logic [2:0] EV_NOT_RIFF = 3'd3;
  localparam logic [2:0] EV_NOT_WEBP = 3'd4;
  localparam logic [2:0] EV_END      = 3'd5;
  localparam logic [2:0] EV_IGNORED  = 3'd6;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       restart;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  event_kind;
    logic [7:0]  payload_byte;
    logic [31:0] chunk_length;
    logic        last_payload;
  } out_item_t;

  typedef struct packed {
    logic [3:0]  phase;
    logic [1:0]  field_cnt;
    logic [31:0] shift;
    logic [31:0] container_size;
    logic [32:0] position;
    logic [31:0] remaining;
    logic        pad;
  } parse_state_t;

  localparam parse_state_t PARSE_CLEAR = '{
    phase:          PH_RIFF,
    field_cnt:      2'd0,
    shift:          32'd0,
    container_size: 32'd0,
    position:       33'd0,
    remaining:      32'd0,
    pad:            1'b0
  };

endpackage
`default_nettype wire

@@ sv/rwcw_step.sv @@
// Next-state and result logic for one input byte of the chunk walker.
`timescale 1ns / 1ps
`default_nettype none
module rwcw_step
  import rwcw_pkg::*;
(
  input  wire in_item_t     item,
  input  wire parse_state_t cur,
  input  wire logic [31:0]  target_fourcc,
  output parse_state_t      nxt,
  output out_item_t         result
);

  parse_state_t st;
  logic         full;
  logic [31:0]  word;
  logic         at_end;

  always_comb begin
    st          = item.restart ? PARSE_CLEAR : cur;
    nxt         = st;
    result      = '0;
    full        = 1'b0;
    word        = st.shift;
    at_end      = 1'b0;

    if (st.phase >= PH_DONE) begin
      result.event_kind = EV_IGNORED;
    end else begin
      result.event_kind = EV_CONSUMED;
      if (st.position != '1) begin
        nxt.position = st.position + 33'd1;
      end
      // container end test against the advanced position
      at_end = nxt.position >= ({1'b0, st.container_size} + HEADER_BIAS);

      if (st.phase <= PH_TSIZE) begin
        word          = {item.data_byte, st.shift[31:8]};
        nxt.shift     = word;
        full          = (st.field_cnt == 2'd3);
        nxt.field_cnt = st.field_cnt + 2'd1;
      end

      unique case (st.phase)
        PH_RIFF: begin
          if (full) begin
            if (word != TAG_RIFF) begin
              result.event_kind = EV_NOT_RIFF;
              nxt.phase         = PH_DONE;
            end else begin
              nxt.phase = PH_RSIZE;
            end
          end
        end
        PH_RSIZE: begin
          if (full) begin
            nxt.container_size = word;
            nxt.phase          = PH_WEBP;
          end
        end
        PH_WEBP: begin
          if (full) begin
            if (word != TAG_WEBP) begin
              result.event_kind = EV_NOT_WEBP;
              nxt.phase         = PH_DONE;
            end else if (at_end) begin
              result.event_kind = EV_END;
              nxt.phase         = PH_DONE;
            end else begin
              nxt.phase     = PH_CTAG;
              nxt.field_cnt = 2'd0;
            end
          end
        end
        PH_CTAG: begin
          if (full) begin
            nxt.phase = (word == target_fourcc) ? PH_TSIZE : PH_OSIZE;
          end
        end
        PH_OSIZE: begin
          if (full) begin
            nxt.remaining = word;
            nxt.pad       = word[0];
            if (word != 32'd0) begin
              nxt.phase = PH_SKIP;
            end else if (at_end) begin
              result.event_kind = EV_END;
              nxt.phase         = PH_DONE;
            end else begin
              nxt.phase     = PH_CTAG;
              nxt.field_cnt = 2'd0;
            end
          end
        end
        PH_TSIZE: begin
          if (full) begin
            result.event_kind   = EV_FOUND;
            result.chunk_length = word;
            nxt.remaining       = word;
            nxt.phase           = (word == 32'd0) ? PH_DONE : PH_PAYLOAD;
          end
        end
        PH_SKIP: begin
          if (st.remaining != 32'd0) begin
            nxt.remaining = st.remaining - 32'd1;
          end else begin
            nxt.pad = 1'b0;
          end
          if (nxt.remaining == 32'd0 && !nxt.pad) begin
            if (at_end) begin
              result.event_kind = EV_END;
              nxt.phase         = PH_DONE;
            end else begin
              nxt.phase     = PH_CTAG;
              nxt.field_cnt = 2'd0;
            end
          end
        end
        PH_PAYLOAD: begin
          result.event_kind   = EV_PAYLOAD;
          result.payload_byte = item.data_byte;
          if (st.remaining != 32'd0) begin
            nxt.remaining = st.remaining - 32'd1;
          end
          if (nxt.remaining == 32'd0) begin
            result.last_payload = 1'b1;
            nxt.phase           = PH_DONE;
          end
        end
        default: begin
          result.event_kind = EV_IGNORED;
          nxt.phase         = PH_DONE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

@@ sv/riff_webp_chunk_walker.sv @@
// Top level of the RIFF/WebP chunk walker: input register, parse state, result register.
//
//   channel | direction | payload    | handshake
//   src     | in        | in_item_t  | src_valid / src_stall
//   dst     | out       | out_item_t | dst_valid / dst_stall
//   cfg     | in        | 32-bit tag | cfg_we (write only)
//
// One byte per cycle unless dst stalls; transactions reach dst via the input register.
// The parse state update for a byte sits between the input and result registers.
// rst (synchronous) clears valids and the parse state, and sets the target tag to "VP8 ".
// A stalled result holds both stages; src_stall follows it in the same cycle.
`timescale 1ns / 1ps
`default_nettype none
module riff_webp_chunk_walker
  import rwcw_pkg::*;
(
  input  wire              clk,
  input  wire              rst,
  input  wire              src_valid,
  output logic             src_stall,
  input  wire in_item_t    src_item,
  output logic             dst_valid,
  input  wire              dst_stall,
  output out_item_t        dst_item,
  input  wire              cfg_we,
  input  wire [31:0]       cfg_wdata
);

  logic         advance;
  logic         hold_valid;
  in_item_t     hold_item;
  parse_state_t state;
  parse_state_t state_next;
  out_item_t    result;
  logic [31:0]  target_fourcc;

  assign advance   = !(dst_valid && dst_stall);
  assign src_stall = !advance;

  rwcw_step u_step (
    .item          (hold_item),
    .cur           (state),
    .target_fourcc (target_fourcc),
    .nxt           (state_next),
    .result        (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      target_fourcc <= TAG_VP8SP;
    end else if (cfg_we) begin
      target_fourcc <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      dst_valid  <= 1'b0;
      state      <= PARSE_CLEAR;
    end else if (advance) begin
      hold_valid <= src_valid;
      dst_valid  <= hold_valid;
      // consume the held byte only when it moves into the result register
      if (hold_valid) begin
        state <= state_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      hold_item <= src_item;
      if (hold_valid) begin
        dst_item <= result;
      end
    end
  end

  a_state_holds_on_stall: assert property (@(posedge clk) disable iff (rst)
    dst_valid && dst_stall |=> $stable(state))
    else $error("parse state moved while result stalled");

  a_count_clear_outside_fields: assert property (@(posedge clk) disable iff (rst)
    state.phase == PH_SKIP || state.phase == PH_PAYLOAD || state.phase == PH_DONE
      |-> state.field_cnt == 2'd0)
    else $error("field byte count nonzero outside header fields");

  a_last_only_on_payload: assert property (@(posedge clk) disable iff (rst)
    dst_valid && dst_item.last_payload |-> dst_item.event_kind == EV_PAYLOAD)
    else $error("last flag on non-payload transaction");

  a_phase_in_range: assert property (@(posedge clk) disable iff (rst)
    state.phase <= PH_DONE)
    else $error("parse phase out of range");

endmodule
`default_nettype wire
